// ----- sv/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// Shared constants and types for the LFU cache table: sizes, the cell
// command and the victim candidate handed along the cell chain.
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int DATA_W     = 32;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W     = IDX_W;
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int CMP_W      = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;
    localparam int CFG_RESET  = 16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [1:0] {
        OP_TOUCH  = 2'b01,
        OP_INSERT = 2'b10
    } op_t;

    typedef struct packed {
        logic                  valid;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_W-1:0]     rank;
        logic [IDX_W-1:0]      idx;
    } cand_t;

    typedef struct packed {
        logic                     en;
        op_t                      op;
        logic                     write_value;
        logic                     evict;
        logic [IDX_W-1:0]         target_idx;
        logic [RANK_W-1:0]        target_rank;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

// ----- sv/lct_cell.sv -----
// ----------------------------------------------------------------------------
// lct_cell
// One table entry: key, value, use count and recency rank. Matches the
// lookup key, applies the broadcast update and passes the better victim
// candidate on to the next cell each cycle.
// ----------------------------------------------------------------------------
module lct_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lct_pkg::IDX_W-1:0]        cell_idx,
    input  logic signed [lct_pkg::DATA_W-1:0] lookup_key,
    input  lct_pkg::cmd_t                    cmd,
    input  lct_pkg::cand_t                   cand_in,
    output lct_pkg::cand_t                   cand_out,
    output logic                             match,
    output logic [lct_pkg::RANK_W-1:0]       rank,
    output logic signed [lct_pkg::DATA_W-1:0] value
);
    import lct_pkg::*;

    logic                     valid_reg, valid_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [RANK_W-1:0]        rank_reg, rank_next;
    cand_t                    cand_reg, cand_next;
    logic                     is_target;
    logic                     take_own;

    assign is_target = (cell_idx == cmd.target_idx);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                OP_TOUCH:
                begin
                    if (is_target)
                    begin
                        if (count_reg != {COUNT_BITS{1'b1}})
                            count_next = count_reg + 1'b1;
                        rank_next = '0;
                        if (cmd.write_value)
                            value_next = cmd.value;
                    end
                    else if (valid_reg && rank_reg < cmd.target_rank)
                        rank_next = rank_reg + 1'b1;
                end
                OP_INSERT:
                begin
                    if (is_target)
                    begin
                        valid_next = 1'b1;
                        key_next   = cmd.key;
                        value_next = cmd.value;
                        count_next = COUNT_BITS'(1);
                        rank_next  = '0;
                    end
                    else if (valid_reg && (!cmd.evict || rank_reg < cmd.target_rank))
                        rank_next = rank_reg + 1'b1;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // victim: lowest count, ties to the least recent (highest rank)
    always_comb
    begin
        take_own = valid_reg && (!cand_in.valid || count_reg < cand_in.count ||
                   (count_reg == cand_in.count && rank_reg > cand_in.rank));
        if (take_own)
        begin
            cand_next.valid = 1'b1;
            cand_next.count = count_reg;
            cand_next.rank  = rank_reg;
            cand_next.idx   = cell_idx;
        end
        else
            cand_next = cand_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

    assign cand_out = cand_reg;
    assign match    = valid_reg && (key_reg == lookup_key);
    assign rank     = rank_reg;
    assign value    = value_reg;

endmodule

// ----- sv/lfu_cache_table_top.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// Fully associative key/value table with LFU replacement and LRU tie break,
// built as a chain of entry cells that ripple the victim candidate.
// ----------------------------------------------------------------------------
// A request is taken in ST_IDLE and passes through ST_LOOKUP, ST_SELECT and
// ST_UPDATE; an evicting put also waits in ST_SEARCH for the victim chain to settle.
// Requests are taken only in ST_IDLE, one at a time, and ST_UPDATE waits on output
// stalls; a finished result waits in the output register while the next request
// is taken.
// Reset: all entries invalid, capacity = 16, no result pending.
module lfu_cache_table_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lct_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [2*lct_pkg::DATA_W-1:0]     s_axis_tdata,  // key, value
    input  logic [0:0]                       s_axis_tuser,  // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lct_pkg::DATA_W-1:0]       m_axis_tdata,  // read_value
    output logic [1:0]                       m_axis_tuser   // hit, evicted
);
    import lct_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_SELECT = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CAP_W-1:0]         capacity_reg;
    logic                     action_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [ENTRIES-1:0]       hit_vec_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [RANK_W-1:0]        hit_rank_reg;
    logic signed [DATA_W-1:0] hit_value_reg;
    logic                     do_touch_reg, do_insert_reg, do_evict_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         settle_reg;
    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic                     out_evicted_reg;
    logic signed [DATA_W-1:0] out_value_reg;

    logic [ENTRIES-1:0]       match_vec;
    logic [RANK_W-1:0]        rank_arr  [ENTRIES];
    logic signed [DATA_W-1:0] value_arr [ENTRIES];
    cand_t                    cand_link [ENTRIES+1];
    cand_t                    victim;
    cmd_t                     cmd;

    logic                     sel_hit;
    logic [IDX_W-1:0]         sel_idx;
    logic [RANK_W-1:0]        sel_rank;
    logic signed [DATA_W-1:0] sel_value;
    logic [CMP_W-1:0]         cap_wide, cap_eff;
    logic                     put_ok;
    logic                     out_free;
    logic                     upd_fire;

    assign cand_link[0] = '0;
    assign victim       = cand_link[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lct_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(g)),
            .lookup_key (key_reg),
            .cmd        (cmd),
            .cand_in    (cand_link[g]),
            .cand_out   (cand_link[g+1]),
            .match      (match_vec[g]),
            .rank       (rank_arr[g]),
            .value      (value_arr[g])
        );
    end

    always_comb
    begin
        sel_idx   = '0;
        sel_rank  = '0;
        sel_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sel_idx   = sel_idx   | (IDX_W'(i) & {IDX_W{hit_vec_reg[i]}});
            sel_rank  = sel_rank  | (rank_arr[i] & {RANK_W{hit_vec_reg[i]}});
            sel_value = sel_value | (value_arr[i] & {DATA_W{hit_vec_reg[i]}});
        end
    end

    assign sel_hit  = |hit_vec_reg;
    assign cap_wide = CMP_W'(capacity_reg);
    assign cap_eff  = (cap_wide > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_wide;
    assign put_ok   = (action_reg == ACT_PUT) && (cap_eff != '0);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign upd_fire = (state_reg == ST_UPDATE) && out_free;

    always_comb
    begin
        cmd.en          = upd_fire && (do_touch_reg || do_insert_reg);
        cmd.op          = do_insert_reg ? OP_INSERT : OP_TOUCH;
        cmd.write_value = (action_reg == ACT_PUT);
        cmd.evict       = do_evict_reg;
        cmd.key         = key_reg;
        cmd.value       = value_reg;
        if (do_touch_reg)
        begin
            cmd.target_idx  = hit_idx_reg;
            cmd.target_rank = hit_rank_reg;
        end
        else if (do_evict_reg)
        begin
            cmd.target_idx  = victim.idx;
            cmd.target_rank = victim.rank;
        end
        else
        begin
            cmd.target_idx  = IDX_W'(occ_reg);
            cmd.target_rank = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_SELECT;
            ST_SELECT:
            begin
                if (!sel_hit && put_ok && CMP_W'(occ_reg) >= cap_eff)
                    state_next = ST_SEARCH;
                else
                    state_next = ST_UPDATE;
            end
            ST_SEARCH: if (settle_reg == OCC_W'(ENTRIES)) state_next = ST_UPDATE;
            ST_UPDATE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_W'(CFG_RESET);
            occ_reg       <= '0;
            settle_reg    <= '0;
            out_valid_reg <= 1'b0;
            do_touch_reg  <= 1'b0;
            do_insert_reg <= 1'b0;
            do_evict_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (cmd.en)
                settle_reg <= '0;
            else if (settle_reg != OCC_W'(ENTRIES))
                settle_reg <= settle_reg + 1'b1;
            if (state_reg == ST_SELECT)
            begin
                do_touch_reg  <= sel_hit && ((action_reg == ACT_GET) || put_ok);
                do_insert_reg <= !sel_hit && put_ok;
                do_evict_reg  <= !sel_hit && put_ok && (CMP_W'(occ_reg) >= cap_eff);
            end
            if (upd_fire && do_insert_reg && !do_evict_reg)
                occ_reg <= occ_reg + 1'b1;
            if (upd_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            action_reg <= s_axis_tuser[0];
            key_reg    <= s_axis_tdata[DATA_W-1:0];
            value_reg  <= s_axis_tdata[2*DATA_W-1:DATA_W];
        end
        if (state_reg == ST_LOOKUP)
            hit_vec_reg <= match_vec;
        if (state_reg == ST_SELECT)
        begin
            hit_reg       <= sel_hit;
            hit_idx_reg   <= sel_idx;
            hit_rank_reg  <= sel_rank;
            hit_value_reg <= sel_value;
        end
        if (upd_fire)
        begin
            out_hit_reg     <= hit_reg;
            out_evicted_reg <= do_evict_reg;
            if (action_reg == ACT_PUT)
                out_value_reg <= '0;
            else if (hit_reg)
                out_value_reg <= hit_value_reg;
            else
                out_value_reg <= '1;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_evicted_reg, out_hit_reg};

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(ENTRIES))
        else $error("occupancy above table size");

    a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SELECT) |-> $onehot0(hit_vec_reg))
        else $error("key present in more than one entry");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && do_evict_reg) |-> victim.valid)
        else $error("eviction without a valid victim");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && do_insert_reg && !do_evict_reg) |-> (occ_reg != OCC_W'(ENTRIES)))
        else $error("insert into full table without eviction");

endmodule

// ----- bench/tb_lfu_cache_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_lfu_cache_table_top
// Stream-level check of the LFU cache table. A table of directed requests
// covers the key and value extremes, get and put, hit and miss, zero
// capacity, capacity above the table size and capacity cut below
// occupancy. Random phases follow, with keys drawn mostly from a small pool
// so that hits, updates and LFU/LRU evictions are frequent. Results are checked
// against directed values or a cache model; stalls are random on both streams.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lct_pkg::*;

    localparam int DRAIN_CYC   = ENTRIES + 8;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 90;
    localparam int POOL_N      = 20;
    localparam int HOLD_CYC    = 400;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] rd;
        logic              ev;
    } resp_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CAP_W-1:0]  cap;
        logic              act;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
        logic              typed;
        resp_t             want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CAP_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [2*DATA_W-1:0]   s_axis_tdata;   // key, value
    logic [0:0]            s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;   // read_value
    logic [1:0]            m_axis_tuser;   // hit, evicted

    // cache model state
    logic                  tbl_valid [ENTRIES];
    logic [DATA_W-1:0]     tbl_key   [ENTRIES];
    logic [DATA_W-1:0]     tbl_val   [ENTRIES];
    logic [COUNT_BITS-1:0] tbl_cnt   [ENTRIES];
    logic [RANK_W-1:0]     tbl_rank  [ENTRIES];
    logic [CAP_W-1:0]      cap_reg;

    resp_t pending_resp [$];

    int err_cnt;
    int n_req;
    int n_results;
    int n_hits;
    int n_evicts;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_req;

    lfu_cache_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic int locate_key(logic [DATA_W-1:0] k);
        int i;
        int e;
        e = -1;
        for (i = 0; i < ENTRIES; i++)
            if (e < 0 && tbl_valid[i] && tbl_key[i] == k)
                e = i;
        return e;
    endfunction

    function automatic void promote_entry(int e);
        int i;
        logic [RANK_W-1:0] r;
        r = tbl_rank[e];
        for (i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && i != e && tbl_rank[i] < r)
                tbl_rank[i]++;
        tbl_rank[e] = '0;
    endfunction

    function automatic void bump_entry(int e);
        if (tbl_cnt[e] != '1)
            tbl_cnt[e]++;
        promote_entry(e);
    endfunction

    function automatic void drop_lfu_victim();
        int i;
        int vic;
        vic = -1;
        for (i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                if (vic < 0 || tbl_cnt[i] < tbl_cnt[vic] ||
                    (tbl_cnt[i] == tbl_cnt[vic] && tbl_rank[i] > tbl_rank[vic]))
                    vic = i;
        if (vic >= 0)
        begin
            for (i = 0; i < ENTRIES; i++)
                if (tbl_valid[i] && tbl_rank[i] > tbl_rank[vic])
                    tbl_rank[i]--;
            tbl_valid[vic] = 1'b0;
        end
    endfunction

    function automatic resp_t cache_access(logic act, logic [DATA_W-1:0] k,
                                           logic [DATA_W-1:0] v);
        resp_t r;
        int    lim;
        int    e;
        int    i;
        int    occ;
        int    slot;
        lim    = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
        e      = locate_key(k);
        r.hit  = (e >= 0);
        r.rd   = '0;
        r.ev   = 1'b0;
        if (act == ACT_GET)
        begin
            if (e >= 0)
            begin
                bump_entry(e);
                r.rd = tbl_val[e];
            end
            else
                r.rd = '1;
        end
        else if (lim != 0)
        begin
            if (e >= 0)
            begin
                tbl_val[e] = v;
                bump_entry(e);
            end
            else
            begin
                occ = 0;
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i])
                        occ++;
                if (occ >= lim)
                begin
                    drop_lfu_victim();
                    r.ev = 1'b1;
                end
                slot = -1;
                for (i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                if (slot >= 0)
                begin
                    for (i = 0; i < ENTRIES; i++)
                        if (tbl_valid[i])
                            tbl_rank[i]++;
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = k;
                    tbl_val[slot]   = v;
                    tbl_cnt[slot]   = COUNT_BITS'(1);
                    tbl_rank[slot]  = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic dir_row_t mk_cap(logic [CAP_W-1:0] c);
        dir_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.cap    = c;
        return r;
    endfunction

    function automatic dir_row_t mk_req(logic act, logic [DATA_W-1:0] k,
                                        logic [DATA_W-1:0] v);
        dir_row_t r;
        r     = '0;
        r.act = act;
        r.k   = k;
        r.v   = v;
        return r;
    endfunction

    function automatic dir_row_t mk_chk(logic act, logic [DATA_W-1:0] k,
                                        logic [DATA_W-1:0] v, logic hit,
                                        logic [DATA_W-1:0] rd, logic ev);
        dir_row_t r;
        r         = mk_req(act, k, v);
        r.typed   = 1'b1;
        r.want.hit = hit;
        r.want.rd  = rd;
        r.want.ev  = ev;
        return r;
    endfunction

    function automatic logic [CAP_W-1:0] phase_cap(int ph);
        case (ph)
            0:       return CAP_W'(16);
            1:       return CAP_W'(5);
            2:       return CAP_W'(31);
            3:       return CAP_W'(1);
            4:       return CAP_W'(0);
            default: return CAP_W'(12);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got %h want %h (result %0d, t=%0t)",
                 what, got, want, n_results, $realtime);
        err_cnt++;
    endtask

    // called just after a falling edge; returns just after a falling edge
    task automatic send_req(input logic act, input logic [DATA_W-1:0] k,
                            input logic [DATA_W-1:0] v, input logic typed,
                            input resp_t want);
        resp_t calc;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, k};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        calc = cache_access(act, k, v);
        pending_resp.push_back(typed ? want : calc);
        n_req++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        s_axis_tvalid <= 1'b0;
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_reg = c;
    endtask

    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_out
        resp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (pending_resp.size() == 0)
                report_mismatch("result with no request pending", m_axis_tdata, '0);
            else
            begin
                want = pending_resp[0];
                pending_resp.delete(0);
                if (m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", DATA_W'(m_axis_tuser[0]), DATA_W'(want.hit));
                if (m_axis_tdata !== want.rd)
                    report_mismatch("read_value", m_axis_tdata, want.rd);
                if (m_axis_tuser[1] !== want.ev)
                    report_mismatch("evicted", DATA_W'(m_axis_tuser[1]), DATA_W'(want.ev));
                if (want.hit)
                    n_hits++;
                if (want.ev)
                    n_evicts++;
            end
        end
    end

    initial
    begin : watchdog
        #40ms;
        $display("Timeout: %0d requests sent, %0d results pending", n_req,
                 pending_resp.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : main
        dir_row_t          rows [$];
        logic [DATA_W-1:0] pool [POOL_N];
        logic [DATA_W-1:0] k;
        int                ph;
        int                n;
        int                i;
        int                n_dir;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        err_cnt       = 0;
        n_req         = 0;
        n_results     = 0;
        n_hits        = 0;
        n_evicts      = 0;
        hold_req      = 0;
        src_idle_pct  = 18;
        sink_idle_pct = 52;
        cap_reg       = CAP_W'(CFG_RESET);
        for (i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;

        // reset capacity is 16
        rows.push_back(mk_chk(ACT_GET, 32'h0000_0000, 32'h0, 1'b0, '1, 1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, 1'b0));
        rows.push_back(mk_chk(ACT_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000,
                              1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0, 1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0, 1'b0));
        rows.push_back(mk_chk(ACT_GET, 32'h8000_0000, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0));
        rows.push_back(mk_chk(ACT_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, '1, 1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'h0000_0000, 32'h1234_5678, 1'b0, '0, 1'b0));
        // cut below occupancy: one victim per new key
        rows.push_back(mk_cap(CAP_W'(2)));
        rows.push_back(mk_chk(ACT_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, 1'b1));
        rows.push_back(mk_chk(ACT_GET, 32'h0000_0000, 32'h0, 1'b0, '1, 1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0, 1'b1));
        rows.push_back(mk_chk(ACT_GET, 32'h5555_5555, 32'h0, 1'b0, '1, 1'b0));
        // zero capacity: puts change nothing
        rows.push_back(mk_cap(CAP_W'(0)));
        rows.push_back(mk_chk(ACT_PUT, 32'h1111_1111, 32'h0, 1'b0, '0, 1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'h7FFF_FFFF, 32'h1, 1'b1, '0, 1'b0));
        rows.push_back(mk_chk(ACT_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0));
        rows.push_back(mk_chk(ACT_GET, 32'h1111_1111, 32'h0, 1'b0, '1, 1'b0));
        // above table size
        rows.push_back(mk_cap(CAP_W'(31)));
        rows.push_back(mk_req(ACT_PUT, 32'hFFFF_FFFF, 32'h0));
        rows.push_back(mk_chk(ACT_GET, 32'hAAAA_AAAA, 32'h0, 1'b1, 32'h5555_5555, 1'b0));
        rows.push_back(mk_cap(CAP_W'(1)));
        rows.push_back(mk_chk(ACT_PUT, 32'h0000_0001, 32'h2, 1'b0, '0, 1'b1));
        rows.push_back(mk_chk(ACT_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, '1, 1'b0));
        rows.push_back(mk_chk(ACT_PUT, 32'h0000_0001, 32'h3, 1'b1, '0, 1'b0));
        rows.push_back(mk_chk(ACT_GET, 32'h0000_0001, 32'h0, 1'b1, 32'h3, 1'b0));
        rows.push_back(mk_cap(CAP_W'(16)));
        rows.push_back(mk_req(ACT_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        rows.push_back(mk_req(ACT_GET, 32'h0F0F_0F0F, 32'h0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            if (rows[i].is_cfg)
                write_capacity(rows[i].cap);
            else
                send_req(rows[i].act, rows[i].k, rows[i].v, rows[i].typed, rows[i].want);
        n_dir = n_req;

        for (i = 0; i < POOL_N; i++)
            pool[i] = $urandom;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'hFFFF_FFFF;

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_capacity(phase_cap(ph));
            src_idle_pct  = (ph < 2) ? 18 : (ph < 4) ? 52 : 0;
            sink_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 18 : 0;
            if (ph == 4)
                hold_req = HOLD_CYC;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                k = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_N - 1)] : $urandom;
                send_req(1'($urandom_range(1)), k, $urandom, 1'b0, '0);
            end
            pool[$urandom_range(POOL_N - 1, 4)] = $urandom;
        end

        s_axis_tvalid <= 1'b0;
        drain_results();

        $display("Ran %0d requests: %0d directed, %0d random over six capacity phases",
                 n_req, n_dir, n_req - n_dir);
        $display("%0d results checked, %0d hits, %0d evictions; capacities 0..31, %0d-cycle hold",
                 n_results, n_hits, n_evicts, HOLD_CYC);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
